### rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg: shared types and unit table for the interval text parser
// Payload structs for both channels, the unit spelling table and its lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

  // Default of the stored unit word length
  localparam int WORD_MAX_DEF = 12;

  // Unit table geometry: longest spelling is twelve letters
  localparam int UNIT_CHARS  = 12;
  localparam int UNIT_TEXT_W = UNIT_CHARS * 8;
  localparam int UNIT_LEN_W  = 4;
  localparam int UNIT_COUNT  = 24;
  localparam int UNIT_IDX_W  = 5;

  // Scale factors into the target total
  localparam logic [31:0] SCALE_ONE   = 32'd1;
  localparam logic [31:0] SCALE_WEEK  = 32'd7;
  localparam logic [31:0] SCALE_YEAR  = 32'd12;
  localparam logic [31:0] SCALE_MSEC  = 32'd1000;
  localparam logic [31:0] SCALE_SEC   = 32'(64'd1000 * 64'd1000);
  localparam logic [31:0] SCALE_MIN   = 32'(64'd60 * 64'd1000 * 64'd1000);
  localparam logic [31:0] SCALE_HOUR  = 32'(64'd60 * 64'd60 * 64'd1000 * 64'd1000);

  typedef enum logic [1:0] {
    TGT_MONTH,
    TGT_DAY,
    TGT_MICRO
  } target_e;

  // One byte of the text per transfer
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } itp_in_t;

  // Totals of one string
  typedef struct packed {
    logic [63:0] months;
    logic [63:0] days;
    logic [63:0] microseconds;
    logic        malformed;
  } itp_out_t;

  typedef struct packed {
    logic [UNIT_TEXT_W-1:0] text;   // first letter in the top byte, zero padded
    logic [UNIT_LEN_W-1:0]  len;
    target_e                target;
    logic [31:0]            scale;
  } unit_entry_t;

  typedef struct packed {
    logic        hit;
    target_e     target;
    logic [31:0] scale;
  } unit_t;

  // Unit spelling table
  function automatic unit_entry_t unit_entry(input logic [UNIT_IDX_W-1:0] idx);
    unit_entry_t e;
    unique case (idx)
      5'd0:  e = '{{"minutes",      40'h0}, 4'd7,  TGT_MICRO, SCALE_MIN};
      5'd1:  e = '{{"minute",       48'h0}, 4'd6,  TGT_MICRO, SCALE_MIN};
      5'd2:  e = '{{"months",       48'h0}, 4'd6,  TGT_MONTH, SCALE_ONE};
      5'd3:  e = '{{"month",        56'h0}, 4'd5,  TGT_MONTH, SCALE_ONE};
      5'd4:  e = '{{"ms",           80'h0}, 4'd2,  TGT_MICRO, SCALE_MSEC};
      5'd5:  e = '{{"milliseconds"},        4'd12, TGT_MICRO, SCALE_MSEC};
      5'd6:  e = '{{"millisecond",   8'h0}, 4'd11, TGT_MICRO, SCALE_MSEC};
      5'd7:  e = '{{"microseconds"},        4'd12, TGT_MICRO, SCALE_ONE};
      5'd8:  e = '{{"microsecond",   8'h0}, 4'd11, TGT_MICRO, SCALE_ONE};
      5'd9:  e = '{{"us",           80'h0}, 4'd2,  TGT_MICRO, SCALE_ONE};
      5'd10: e = '{{"secs",         64'h0}, 4'd4,  TGT_MICRO, SCALE_SEC};
      5'd11: e = '{{"sec",          72'h0}, 4'd3,  TGT_MICRO, SCALE_SEC};
      5'd12: e = '{{"seconds",      40'h0}, 4'd7,  TGT_MICRO, SCALE_SEC};
      5'd13: e = '{{"second",       48'h0}, 4'd6,  TGT_MICRO, SCALE_SEC};
      5'd14: e = '{{"hrs",          72'h0}, 4'd3,  TGT_MICRO, SCALE_HOUR};
      5'd15: e = '{{"hr",           80'h0}, 4'd2,  TGT_MICRO, SCALE_HOUR};
      5'd16: e = '{{"hours",        56'h0}, 4'd5,  TGT_MICRO, SCALE_HOUR};
      5'd17: e = '{{"hour",         64'h0}, 4'd4,  TGT_MICRO, SCALE_HOUR};
      5'd18: e = '{{"days",         64'h0}, 4'd4,  TGT_DAY,   SCALE_ONE};
      5'd19: e = '{{"day",          72'h0}, 4'd3,  TGT_DAY,   SCALE_ONE};
      5'd20: e = '{{"weeks",        56'h0}, 4'd5,  TGT_DAY,   SCALE_WEEK};
      5'd21: e = '{{"week",         64'h0}, 4'd4,  TGT_DAY,   SCALE_WEEK};
      5'd22: e = '{{"years",        56'h0}, 4'd5,  TGT_MONTH, SCALE_YEAR};
      5'd23: e = '{{"year",         64'h0}, 4'd4,  TGT_MONTH, SCALE_YEAR};
      default: e = '0;
    endcase
    return e;
  endfunction

  // Match a zero-padded word of known length against all spellings
  function automatic unit_t unit_find(input logic [UNIT_TEXT_W-1:0] word,
                                      input logic [UNIT_LEN_W-1:0]  len);
    unit_t       res;
    unit_entry_t e;
    res = '0;
    for (int i = 0; i < UNIT_COUNT; i++) begin
      e = unit_entry(UNIT_IDX_W'(i));
      if (e.len == len && e.text == word) begin
        res.hit    = 1'b1;
        res.target = e.target;
        res.scale  = e.scale;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/interval_text_parser_top.sv
// ----------------------------------------------------------------------------
// interval_text_parser_top: interval text to month/day/microsecond totals
// Parses one character per cycle unless stalled, scales each term by its unit
// and emits three totals and a malformed flag after a string's last character.
// ----------------------------------------------------------------------------
//
//   channel   direction   payload     handshake
//   in        input       itp_in_t    in_valid_i / in_stall_o
//   out       output      itp_out_t   out_valid_o / out_stall_i
//
// One character is taken every cycle unless the input is stalled. The
// character parser is a single register stage; each finished term then goes
// through a 32-bit split multiply, a partial-product merge and the total
// accumulators before the result is registered at the output.
// Reset clears the parser, the pipeline and the totals; no sweep is needed.
// Input stalls only while a result waits in the output register and the next
// string's result is ready behind it.

`default_nettype none

module interval_text_parser_top
  import itp_pkg::*;
#(
  parameter int WORD_MAX = WORD_MAX_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire itp_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output itp_out_t      out_data_o
);

  localparam int LEN_W = $clog2(WORD_MAX + 1);
  localparam int IDX_W = $clog2(WORD_MAX);

  typedef enum logic [1:0] {
    PH_BETWEEN,
    PH_COUNT,
    PH_GAP,
    PH_WORD
  } phase_e;

  // Term event leaving the parser
  typedef struct packed {
    logic        term;
    logic        fin;
    logic        err;
    target_e     target;
    logic [31:0] scale;
    logic [63:0] count;
  } ev_t;

  // Partial products of count times scale
  typedef struct packed {
    logic        term;
    logic        fin;
    logic        err;
    target_e     target;
    logic [63:0] prod_lo;
    logic [31:0] prod_hi;
  } pp_t;

  // Scaled term ready for the totals
  typedef struct packed {
    logic        term;
    logic        fin;
    logic        err;
    target_e     target;
    logic [63:0] prod;
  } sc_t;

  phase_e       phase_q;
  logic [63:0]  count_q;
  logic [LEN_W-1:0] len_q;
  logic         err_q;
  logic [7:0]   letters_q [WORD_MAX];

  ev_t          s1_q;
  pp_t          s2_q;
  sc_t          s3_q;
  logic [63:0]  month_q, day_q, micro_q;
  logic         out_valid_q;
  itp_out_t     out_data_q;

  logic         adv;
  logic         in_acc;
  logic [7:0]   ch;
  logic         last;
  logic         is_sp, is_dg, is_lt;
  logic [3:0]   digit;

  logic         wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [LEN_W-1:0] view_len;
  logic [UNIT_TEXT_W-1:0] word_masked;
  unit_t        unit;
  logic         hit;

  phase_e       t_phase;
  logic [63:0]  t_count;
  logic [LEN_W-1:0] t_len;
  logic         t_err;
  logic         term;
  logic         do_start;
  logic         fin_term, fin_err;
  ev_t          ev;

  logic [63:0]  add_m, add_d, add_u;
  logic [63:0]  mon_sum, day_sum, mic_sum;

  // Advance everything unless a finished string is blocked at the output
  assign adv        = !(out_valid_q && out_stall_i && s3_q.fin);
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && adv;

  // Character classes
  assign ch    = in_data_i.char_code;
  assign last  = in_data_i.last_char;
  assign is_sp = (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
  assign is_dg = (ch >= 8'd48) && (ch <= 8'd57);
  assign is_lt = (ch >= 8'd65 && ch <= 8'd90) || (ch >= 8'd97 && ch <= 8'd122);
  assign digit = ch[3:0];

  // Letter store: first letter after the gap, or next letter of a word
  always_comb begin
    wr_en    = 1'b0;
    wr_idx   = '0;
    view_len = len_q;
    if (!err_q && is_lt) begin
      if (phase_q == PH_GAP) begin
        wr_en    = 1'b1;
        view_len = LEN_W'(1);
      end else if (phase_q == PH_WORD && len_q < LEN_W'(WORD_MAX)) begin
        wr_en    = 1'b1;
        wr_idx   = len_q[IDX_W-1:0];
        view_len = len_q + LEN_W'(1);
      end
    end
  end

  // Build the zero-padded word including a letter stored this cycle
  always_comb begin
    word_masked = '0;
    for (int i = 0; i < UNIT_CHARS; i++) begin
      if (LEN_W'(i) < view_len) begin
        word_masked[UNIT_TEXT_W-1-8*i -: 8] =
          (wr_en && wr_idx == IDX_W'(i)) ? ch : letters_q[i];
      end
    end
  end

  assign unit = unit_find(word_masked, view_len[UNIT_LEN_W-1:0]);
  assign hit  = unit.hit && (view_len <= LEN_W'(UNIT_CHARS));

  // Term grammar step for one character
  always_comb begin
    t_phase  = phase_q;
    t_count  = count_q;
    t_len    = len_q;
    t_err    = err_q;
    term     = 1'b0;
    do_start = 1'b0;
    if (!err_q) begin
      unique case (phase_q)
        PH_BETWEEN: do_start = 1'b1;
        PH_COUNT: begin
          if (is_dg) begin
            t_count = {count_q[60:0], 3'b000} + {count_q[62:0], 1'b0} + 64'(digit);
          end else if (is_sp) begin
            t_phase = PH_GAP;
          end else begin
            t_err = 1'b1;
          end
        end
        PH_GAP: begin
          if (is_lt) begin
            t_phase = PH_WORD;
            t_len   = view_len;
          end else if (!is_sp) begin
            t_err = 1'b1;
          end
        end
        PH_WORD: begin
          if (is_lt) begin
            if (wr_en) t_len = view_len;
            else       t_err = 1'b1;
          end else if (hit) begin
            term     = 1'b1;
            do_start = 1'b1;
          end else begin
            t_err = 1'b1;
          end
        end
        default: t_err = 1'b1;
      endcase
    end
    // Open a new term, or stay between terms on whitespace
    if (do_start) begin
      if (is_sp) begin
        t_phase = PH_BETWEEN;
      end else if (is_dg) begin
        t_count = 64'(digit);
        t_phase = PH_COUNT;
      end else begin
        t_err = 1'b1;
      end
    end
    // Close the string on its last character
    fin_term = term;
    fin_err  = t_err;
    if (last && !t_err) begin
      if (t_phase == PH_WORD) begin
        if (hit) fin_term = 1'b1;
        else     fin_err  = 1'b1;
      end else if (t_phase == PH_COUNT || t_phase == PH_GAP) begin
        fin_err = 1'b1;
      end
    end
    ev.term   = fin_term;
    ev.fin    = last;
    ev.err    = fin_err;
    ev.target = unit.target;
    ev.scale  = unit.scale;
    ev.count  = count_q;
  end

  // Parser state: hold, advance, or clear after the last character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BETWEEN;
      count_q <= '0;
      len_q   <= '0;
      err_q   <= 1'b0;
    end else if (in_acc) begin
      if (last) begin
        phase_q <= PH_BETWEEN;
        count_q <= '0;
        len_q   <= '0;
        err_q   <= 1'b0;
      end else begin
        phase_q <= t_phase;
        count_q <= t_count;
        len_q   <= t_len;
        err_q   <= t_err;
      end
    end
  end

  // Unit word letters
  always_ff @(posedge clk_i) begin
    if (in_acc && wr_en) begin
      letters_q[wr_idx] <= ch;
    end
  end

  // Term pipeline: event, partial products, merged product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else if (adv) begin
      s1_q <= in_acc ? ev : '0;
      s2_q.term    <= s1_q.term;
      s2_q.fin     <= s1_q.fin;
      s2_q.err     <= s1_q.err;
      s2_q.target  <= s1_q.target;
      s2_q.prod_lo <= 64'(s1_q.count[31:0]) * 64'(s1_q.scale);
      s2_q.prod_hi <= 32'(s1_q.count[63:32] * s1_q.scale);
      s3_q.term    <= s2_q.term;
      s3_q.fin     <= s2_q.fin;
      s3_q.err     <= s2_q.err;
      s3_q.target  <= s2_q.target;
      s3_q.prod    <= s2_q.prod_lo + {s2_q.prod_hi, 32'h0};
    end
  end

  // Add the scaled term into its total
  always_comb begin
    add_m   = (s3_q.term && s3_q.target == TGT_MONTH) ? s3_q.prod : '0;
    add_d   = (s3_q.term && s3_q.target == TGT_DAY)   ? s3_q.prod : '0;
    add_u   = (s3_q.term && s3_q.target == TGT_MICRO) ? s3_q.prod : '0;
    mon_sum = month_q + add_m;
    day_sum = day_q + add_d;
    mic_sum = micro_q + add_u;
  end

  // Totals and output transfer flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      month_q     <= '0;
      day_q       <= '0;
      micro_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        if (s3_q.fin) begin
          month_q <= '0;
          day_q   <= '0;
          micro_q <= '0;
        end else begin
          month_q <= mon_sum;
          day_q   <= day_sum;
          micro_q <= mic_sum;
        end
      end
      if (adv && s3_q.fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; zero totals when malformed
  always_ff @(posedge clk_i) begin
    if (adv && s3_q.fin) begin
      out_data_q.malformed    <= s3_q.err;
      out_data_q.months       <= s3_q.err ? '0 : mon_sum;
      out_data_q.days         <= s3_q.err ? '0 : day_sum;
      out_data_q.microseconds <= s3_q.err ? '0 : mic_sum;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Input stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // Malformed result carries zero totals
  a_malformed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.malformed) |->
      (out_data_o.months == '0 && out_data_o.days == '0 &&
       out_data_o.microseconds == '0))
    else $error("malformed result with nonzero totals");

  // Last character leaves the parser clean
  a_clean_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last) |=> (phase_q == PH_BETWEEN && len_q == '0 && !err_q &&
                          count_q == '0))
    else $error("parser not cleared after last character");

  // Word length stays within storage, and a word is never empty
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WORD) |-> (len_q != '0 && len_q <= LEN_W'(WORD_MAX)))
    else $error("unit word length out of range");

  // A finished string enters the term pipeline right after its last character
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last) |=> s1_q.fin)
    else $error("end of string lost entering the term pipeline");

endmodule

`default_nettype wire

### tb/tb_interval_text_parser_top.sv
// ----------------------------------------------------------------------------
// tb_interval_text_parser_top: self-checking bench for the interval parser
// Feeds interval texts one byte per transfer: a short table of directed
// strings, then random well-formed, mutated and noise strings under several
// idle and stall mixes. Results are checked against table totals or a parser model.
// ----------------------------------------------------------------------------

module tb_interval_text_parser_top;
  import itp_pkg::*;

  localparam int NAME_MAX     = WORD_MAX_DEF;
  localparam int NAME_W       = 8 * NAME_MAX;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RAND_BYTES   = 160;
  localparam int PHASES       = 4;

  localparam logic [63:0] US_MSEC = 64'd1000;
  localparam logic [63:0] US_SEC  = 64'd1_000_000;
  localparam logic [63:0] US_MIN  = 64'd60_000_000;
  localparam logic [63:0] US_HOUR = 64'd3_600_000_000;

  localparam itp_out_t MALFORMED = '{64'd0, 64'd0, 64'd0, 1'b1};
  localparam itp_out_t NO_TOTALS = '{64'd0, 64'd0, 64'd0, 1'b0};

  // Where the scanner stands inside a term
  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_DIGITS,
    SCAN_SPACE,
    SCAN_LETTERS
  } scan_e;

  typedef struct {
    string      txt;     // empty text: send the lone byte in code
    logic [7:0] code;
    bit         typed;
    itp_out_t   want;
  } text_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  itp_in_t  in_data_i   = '0;
  logic     in_stall_o;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  itp_out_t out_data_o;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned tx_idle_by_phase [PHASES] = '{0, 66, 0, 28};
  int unsigned rx_stall_by_phase[PHASES] = '{0, 0, 66, 28};

  itp_out_t    totals_q[$];
  logic [7:0]  text_q[$];
  text_row_t   text_rows[$];
  int          err_count  = 0;
  int          bytes_sent = 0;

  string unit_words[24] = '{
    "minutes", "minute", "months", "month", "ms", "milliseconds",
    "millisecond", "microseconds", "microsecond", "us", "secs", "sec",
    "seconds", "second", "hrs", "hr", "hours", "hour", "days", "day",
    "weeks", "week", "years", "year"
  };

  // Parser model state
  scan_e             scan_st  = SCAN_IDLE;
  logic [63:0]       term_cnt = '0;
  logic [NAME_W-1:0] word_vec = '0;
  int                word_n   = 0;
  logic [63:0]       sum_mon  = '0;
  logic [63:0]       sum_day  = '0;
  logic [63:0]       sum_us   = '0;
  bit                broken   = 1'b0;

  always #1 clk_i = ~clk_i;

  interval_text_parser_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  function automatic bit is_blank(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  task automatic clear_scan();
    scan_st  = SCAN_IDLE;
    term_cnt = '0;
    word_vec = '0;
    word_n   = 0;
    sum_mon  = '0;
    sum_day  = '0;
    sum_us   = '0;
    broken   = 1'b0;
  endtask

  // Look up the finished word (right aligned, zero filled) and add the term
  task automatic close_word();
    bit          hit;
    target_e     tgt;
    logic [63:0] scale;
    hit   = 1'b1;
    tgt   = TGT_MICRO;
    scale = 64'd1;
    case (word_vec)
      NAME_W'("minutes"), NAME_W'("minute"): scale = US_MIN;
      NAME_W'("months"), NAME_W'("month"): tgt = TGT_MONTH;
      NAME_W'("ms"), NAME_W'("milliseconds"), NAME_W'("millisecond"): scale = US_MSEC;
      NAME_W'("microseconds"), NAME_W'("microsecond"), NAME_W'("us"): scale = 64'd1;
      NAME_W'("secs"), NAME_W'("sec"), NAME_W'("seconds"), NAME_W'("second"):
        scale = US_SEC;
      NAME_W'("hrs"), NAME_W'("hr"), NAME_W'("hours"), NAME_W'("hour"): scale = US_HOUR;
      NAME_W'("days"), NAME_W'("day"): tgt = TGT_DAY;
      NAME_W'("weeks"), NAME_W'("week"): begin
        tgt   = TGT_DAY;
        scale = 64'd7;
      end
      NAME_W'("years"), NAME_W'("year"): begin
        tgt   = TGT_MONTH;
        scale = 64'd12;
      end
      default: hit = 1'b0;
    endcase
    if (!hit) begin
      broken = 1'b1;
    end else begin
      case (tgt)
        TGT_MONTH: sum_mon = sum_mon + term_cnt * scale;
        TGT_DAY:   sum_day = sum_day + term_cnt * scale;
        default:   sum_us  = sum_us + term_cnt * scale;
      endcase
    end
  endtask

  task automatic open_term(input logic [7:0] c);
    if (is_blank(c)) begin
      scan_st = SCAN_IDLE;
    end else if (is_digit(c)) begin
      term_cnt = 64'(c - 8'd48);
      scan_st  = SCAN_DIGITS;
    end else begin
      broken = 1'b1;
    end
  endtask

  // Advance the model by one byte; a result appears on the last byte
  task automatic parse_byte(input itp_in_t it, output bit emit, output itp_out_t res);
    logic [7:0] c;
    c = it.char_code;
    if (!broken) begin
      case (scan_st)
        SCAN_IDLE: open_term(c);
        SCAN_DIGITS: begin
          if (is_digit(c)) term_cnt = term_cnt * 64'd10 + 64'(c - 8'd48);
          else if (is_blank(c)) scan_st = SCAN_SPACE;
          else broken = 1'b1;
        end
        SCAN_SPACE: begin
          if (is_alpha(c)) begin
            word_vec = NAME_W'(c);
            word_n   = 1;
            scan_st  = SCAN_LETTERS;
          end else if (!is_blank(c)) begin
            broken = 1'b1;
          end
        end
        default: begin
          if (is_alpha(c)) begin
            if (word_n >= NAME_MAX) begin
              broken = 1'b1;
            end else begin
              word_vec = {word_vec[NAME_W-9:0], c};
              word_n++;
            end
          end else begin
            close_word();
            if (!broken) open_term(c);
          end
        end
      endcase
    end
    emit = it.last_char;
    res  = NO_TOTALS;
    if (it.last_char) begin
      if (!broken) begin
        if (scan_st == SCAN_LETTERS) close_word();
        else if (scan_st != SCAN_IDLE) broken = 1'b1;
      end
      if (broken) res = MALFORMED;
      else res = '{sum_mon, sum_day, sum_us, 1'b0};
      clear_scan();
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    err_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk_i) begin : result_check
    itp_out_t want;
    if (out_valid_o && !out_stall_i) begin
      if (totals_q.size() == 0) begin
        report_mismatch("result transfer with no totals pending");
      end else begin
        want = totals_q.pop_front();
        if (out_data_o.months !== want.months)
          report_mismatch($sformatf("months got %0d want %0d",
                                    out_data_o.months, want.months));
        if (out_data_o.days !== want.days)
          report_mismatch($sformatf("days got %0d want %0d",
                                    out_data_o.days, want.days));
        if (out_data_o.microseconds !== want.microseconds)
          report_mismatch($sformatf("microseconds got %0d want %0d",
                                    out_data_o.microseconds, want.microseconds));
        if (out_data_o.malformed !== want.malformed)
          report_mismatch($sformatf("malformed got %0b want %0b",
                                    out_data_o.malformed, want.malformed));
      end
    end
  end

  // Random receiver stall, redrawn every cycle
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < rx_stall_pct);
  end

  // End the run when no transfer happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("tb_interval_text_parser_top: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Offer one byte, hold it until the transfer, then run the model on it
  task automatic send_byte(input logic [7:0] c, input bit last, input bit typed,
                           input itp_out_t want);
    bit       emit;
    itp_out_t got;
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = '{char_code: c, last_char: last};
    do @(posedge clk_i); while (in_stall_o);
    parse_byte(in_data_i, emit, got);
    if (emit) totals_q.push_back(typed ? want : got);
    bytes_sent++;
  endtask

  task automatic send_text(input bit typed, input itp_out_t want);
    for (int i = 0; i < text_q.size(); i++)
      send_byte(text_q[i], i == text_q.size() - 1, typed, want);
  endtask

  // Hold the input idle until every pending result has arrived
  task automatic wait_for_totals();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (totals_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(5))
      0: return 8'd9;
      1: return 8'd10;
      2: return 8'd11;
      3: return 8'd12;
      4: return 8'd13;
      default: return 8'd32;
    endcase
  endfunction

  // Count, gap and unit word; now and then a random or overlong word
  task automatic push_term();
    int    ndig;
    string w;
    ndig = ($urandom_range(15) == 0) ? $urandom_range(19, 22) : $urandom_range(1, 3);
    repeat (ndig) text_q.push_back(8'd48 + 8'($urandom_range(9)));
    text_q.push_back(pick_blank());
    repeat ($urandom_range(1)) text_q.push_back(pick_blank());
    if ($urandom_range(9) != 0) begin
      w = unit_words[$urandom_range(23)];
      for (int i = 0; i < w.len(); i++) text_q.push_back(w[i]);
    end else begin
      repeat ($urandom_range(1, NAME_MAX + 1))
        text_q.push_back(8'd65 + 8'($urandom_range(25)) + ($urandom_range(1) ? 8'd32 : 8'd0));
    end
  endtask

  // Mostly well-formed strings, some mutated, some plain noise
  task automatic build_random_text();
    int kind;
    int idx;
    kind = $urandom_range(99);
    text_q.delete();
    if (kind >= 90) begin
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(2)) text_q.push_back(pick_blank());
      for (int t = $urandom_range(1, 3); t > 0; t--) begin
        push_term();
        if (t > 1 && $urandom_range(1) != 0)
          repeat ($urandom_range(1, 2)) text_q.push_back(pick_blank());
      end
      if ($urandom_range(3) == 0) text_q.push_back(pick_blank());
      if (kind >= 70) begin
        idx = $urandom_range(text_q.size() - 1);
        case ($urandom_range(2))
          0: text_q[idx] = 8'($urandom_range(255));
          1: text_q[idx] = text_q[idx] ^ 8'h20;
          default: while (text_q.size() > idx + 1) void'(text_q.pop_back());
        endcase
      end
    end
  endtask

  initial begin : main
    int phase_start;
    text_rows.push_back('{"", 8'h00, 1'b1, MALFORMED});
    text_rows.push_back('{"", 8'hFF, 1'b1, MALFORMED});
    text_rows.push_back('{" ", 8'h00, 1'b1, NO_TOTALS});
    text_rows.push_back('{"7", 8'h00, 1'b1, MALFORMED});
    text_rows.push_back('{"4 \t", 8'h00, 1'b1, MALFORMED});
    text_rows.push_back('{"1 day", 8'h00, 1'b1, '{64'd0, 64'd1, 64'd0, 1'b0}});
    text_rows.push_back('{"2 weeks", 8'h00, 1'b1, '{64'd0, 64'd14, 64'd0, 1'b0}});
    text_rows.push_back('{"3 years", 8'h00, 1'b1, '{64'd36, 64'd0, 64'd0, 1'b0}});
    text_rows.push_back('{"1 wk", 8'h00, 1'b1, MALFORMED});
    text_rows.push_back('{"1 Day", 8'h00, 1'b1, MALFORMED});
    text_rows.push_back('{"5 ,", 8'h00, 1'b1, MALFORMED});
    text_rows.push_back('{"9 abcdefghijklm", 8'h00, 1'b1, MALFORMED});
    text_rows.push_back('{"x1 day", 8'h00, 1'b1, MALFORMED});
    text_rows.push_back('{"1 milliseconds", 8'h00, 1'b0, NO_TOTALS});
    text_rows.push_back('{"2 microseconds 3 us", 8'h00, 1'b0, NO_TOTALS});
    text_rows.push_back('{"3 hrs 1 hour", 8'h00, 1'b0, NO_TOTALS});
    text_rows.push_back('{"18446744073709551617 us", 8'h00, 1'b0, NO_TOTALS});
    text_rows.push_back('{" \t1\n\vminute\f\r2sec", 8'h00, 1'b0, NO_TOTALS});
    text_rows.push_back('{"1 day2 hr 4 ms", 8'h00, 1'b0, NO_TOTALS});
    text_rows.push_back('{"6 months 5 seconds 7 month 8 week", 8'h00, 1'b0, NO_TOTALS});
    text_rows.push_back('{"1 secs 2 second 3 minutes 4 hours 5 microsecond 6 millisecond 1 year 1 days",
                          8'h00, 1'b0, NO_TOTALS});

    // Hold reset, release on a falling edge
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table
    foreach (text_rows[r]) begin
      text_q.delete();
      if (text_rows[r].txt.len() == 0) begin
        text_q.push_back(text_rows[r].code);
      end else begin
        for (int i = 0; i < text_rows[r].txt.len(); i++) text_q.push_back(text_rows[r].txt[i]);
      end
      send_text(text_rows[r].typed, text_rows[r].want);
    end
    wait_for_totals();

    // Random strings under each idle and stall mix
    for (int ph = 0; ph < PHASES; ph++) begin
      tx_idle_pct  = tx_idle_by_phase[ph];
      rx_stall_pct = rx_stall_by_phase[ph];
      phase_start  = bytes_sent;
      while (bytes_sent - phase_start < RAND_BYTES / PHASES) begin
        build_random_text();
        send_text(1'b0, NO_TOTALS);
      end
      wait_for_totals();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (totals_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", totals_q.size()));
    if (err_count == 0) begin
      $display("tb_interval_text_parser_top: PASS");
    end else begin
      $display("tb_interval_text_parser_top: FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/itp_pkg.sv
rtl/interval_text_parser_top.sv
tb/tb_interval_text_parser_top.sv
